// ===== sv/nshot_modifier_tracker_assert.svh =====
// Assertion macros shared by the one-shot modifier tracker RTL.
// Every macro expects signals named clk and arst_n in the using module.
`ifndef NSHOT_MODIFIER_TRACKER_ASSERT_SVH
`define NSHOT_MODIFIER_TRACKER_ASSERT_SVH

// Plain property checked at every clock edge outside reset.
`define NMT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define NMT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/nmt_pkg.sv =====
// Package for the one-shot modifier tracker: slot modes, event and result
// structures, and configuration register indexes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nmt_pkg;

	localparam int unsigned KEYCODE_W  = 16;
	localparam int unsigned MASK_W     = 8;
	localparam int unsigned LIMIT_W    = 4;
	localparam int unsigned USES_W     = 5;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 64;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TRIG_LOW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIG_LAST  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MOD_MASKS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMITS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CANCEL     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LAYER_KEYS = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_NAV_SPACE  = 3'd6;

	typedef enum logic [1:0] {
		MODE_IDLE        = 2'd0,
		MODE_QUEUED      = 2'd1,
		MODE_DOWN_UNUSED = 2'd2,
		MODE_DOWN_USED   = 2'd3
	} mode_t;

	// One decoded event, shared by all slots.
	typedef struct packed {
		logic                 force_shot;
		logic [KEYCODE_W-1:0] keycode;
		logic                 press;
		logic                 cancel;
		logic                 ignored;
	} event_t;

	// Masks a single slot turns on and off for the current event.
	typedef struct packed {
		logic [MASK_W-1:0] mods_on;
		logic [MASK_W-1:0] mods_off;
	} slot_result_t;

endpackage

`default_nettype wire

// ===== sv/nmt_slot.sv =====
// One modifier slot: mode and use-count registers plus the next-state logic.
// Depends on nmt_pkg and nshot_modifier_tracker_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "nshot_modifier_tracker_assert.svh"

module nmt_slot (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          update_en,
	input  wire nmt_pkg::event_t               ev,
	input  wire logic [nmt_pkg::KEYCODE_W-1:0] trigger,
	input  wire logic [nmt_pkg::MASK_W-1:0]    mod_mask,
	input  wire logic [nmt_pkg::LIMIT_W-1:0]   shot_limit,
	output nmt_pkg::slot_result_t              result
);

	nmt_pkg::mode_t              mode_q, mode_d;
	logic [nmt_pkg::USES_W-1:0]  uses_q, uses_d, uses_inc, end_cnt;
	logic [nmt_pkg::LIMIT_W-1:0] limit_eff;
	logic                        hit, count_it;

	assign hit       = (ev.keycode == trigger);
	assign limit_eff = (shot_limit == '0) ? nmt_pkg::LIMIT_W'(1) : shot_limit;
	assign end_cnt   = {limit_eff, 1'b0};
	assign uses_inc  = uses_q + nmt_pkg::USES_W'(1);

	always_comb begin
		mode_d          = mode_q;
		uses_d          = uses_q;
		result.mods_on  = '0;
		result.mods_off = '0;
		count_it        = 1'b0;
		if (ev.force_shot) begin
			if (hit) begin
				result.mods_on = mod_mask;
				mode_d         = nmt_pkg::MODE_QUEUED;
				uses_d         = '0;
			end
		end else if (hit) begin
			if (ev.press) begin
				if (mode_q == nmt_pkg::MODE_IDLE) begin
					result.mods_on = mod_mask;
				end
				mode_d = nmt_pkg::MODE_DOWN_UNUSED;
				uses_d = '0;
			end else begin
				unique case (mode_q)
					nmt_pkg::MODE_DOWN_UNUSED: begin
						mode_d = nmt_pkg::MODE_QUEUED;
					end
					nmt_pkg::MODE_DOWN_USED: begin
						mode_d          = nmt_pkg::MODE_IDLE;
						result.mods_off = mod_mask;
					end
					default: begin
						mode_d = mode_q;
					end
				endcase
			end
		end else if (ev.press) begin
			if (ev.cancel && (mode_q != nmt_pkg::MODE_IDLE)) begin
				mode_d          = nmt_pkg::MODE_IDLE;
				uses_d          = '0;
				result.mods_off = mod_mask;
			end else if ((mode_q == nmt_pkg::MODE_QUEUED) && !ev.ignored) begin
				count_it = 1'b1;
			end
		end else if (!ev.ignored) begin
			unique case (mode_q)
				nmt_pkg::MODE_DOWN_UNUSED: begin
					mode_d = nmt_pkg::MODE_DOWN_USED;
				end
				nmt_pkg::MODE_QUEUED: begin
					count_it = 1'b1;
				end
				default: begin
					mode_d = mode_q;
				end
			endcase
		end
		// A counted key either advances the count or ends the queued shot.
		if (count_it) begin
			if (uses_inc == end_cnt) begin
				mode_d          = nmt_pkg::MODE_IDLE;
				uses_d          = '0;
				result.mods_off = mod_mask;
			end else begin
				uses_d = uses_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= nmt_pkg::MODE_IDLE;
			uses_q <= '0;
		end else if (update_en) begin
			mode_q <= mode_d;
			uses_q <= uses_d;
		end
	end

	// Only a queued shot ever holds a nonzero count.
	`NMT_ASSERT(a_uses_only_queued, (uses_q == '0) || (mode_q == nmt_pkg::MODE_QUEUED), "slot count nonzero outside queued mode")
	// A trigger press always leaves the slot held and unused.
	`NMT_ASSERT_NEXT(a_press_holds, update_en && !ev.force_shot && hit && ev.press, (mode_q == nmt_pkg::MODE_DOWN_UNUSED) && (uses_q == '0), "trigger press did not hold slot")

endmodule

`default_nettype wire

// ===== sv/nshot_modifier_tracker.sv =====
// Top level of the one-shot modifier tracker: configuration registers, input
// stage, event decode, slot array and output register. Depends on nmt_pkg,
// nmt_slot and nshot_modifier_tracker_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "nshot_modifier_tracker_assert.svh"

// Usage:
// Key events enter on the s_axis channel. tuser carries the operation bit
// (0 for a key event, 1 to force a one-shot on every slot whose trigger
// equals the keycode). tdata carries the keycode, the press flag and the
// navigation layer flag. Each accepted transaction yields exactly one result
// transaction on m_axis, whose tdata holds the modifier masks to register and
// to unregister, in the same order as the inputs.
// From input acceptance to m_axis_tvalid the transaction passes through the
// input register, then all slots update in parallel and the masks land in the
// output register. Throughput is one transaction per cycle while the receiver
// keeps up; the single slot-update step between the two registers sets that
// figure. When the receiver stalls, the result waits in the output register
// and one more transaction may sit in the input register; s_axis_tready then
// drops. Slot state only advances when a transaction moves into the output
// register. Reset clears all slots to up idle with a zero count and all
// configuration registers to zero. Configuration is to be written through
// cfg_wr_en, cfg_index and cfg_data only while no transaction is in flight;
// the block itself does not enforce this.

module nshot_modifier_tracker #(
	parameter int unsigned SLOT_COUNT = 5
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Configuration write port.
	input  wire logic                           cfg_wr_en,
	input  wire logic [nmt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [nmt_pkg::CFG_DATA_W-1:0] cfg_data,
	// Input channel.
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// tdata: keycode [15:0], pressed [16], nav_layer_on [17], zero [23:18]
	input  wire logic [23:0]                    s_axis_tdata,
	// tuser: operation [0]
	input  wire logic                           s_axis_tuser,
	// Output channel.
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// tdata: mods_to_register [7:0], mods_to_unregister [15:8]
	output logic [15:0]                         m_axis_tdata
);

	localparam int unsigned KW = nmt_pkg::KEYCODE_W;
	localparam int unsigned MW = nmt_pkg::MASK_W;
	localparam int unsigned LW = nmt_pkg::LIMIT_W;

	// Configuration registers.
	logic [4*KW-1:0] trig_low_q;
	logic [KW-1:0]   trig_last_q;
	logic [5*MW-1:0] mod_masks_q;
	logic [5*LW-1:0] limits_q;
	logic [2*KW-1:0] cancel_q;
	logic [2*KW-1:0] layer_q;
	logic [KW-1:0]   nav_space_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_low_q  <= '0;
			trig_last_q <= '0;
			mod_masks_q <= '0;
			limits_q    <= '0;
			cancel_q    <= '0;
			layer_q     <= '0;
			nav_space_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				nmt_pkg::REG_TRIG_LOW:   trig_low_q  <= cfg_data;
				nmt_pkg::REG_TRIG_LAST:  trig_last_q <= cfg_data[KW-1:0];
				nmt_pkg::REG_MOD_MASKS:  mod_masks_q <= cfg_data[5*MW-1:0];
				nmt_pkg::REG_LIMITS:     limits_q    <= cfg_data[5*LW-1:0];
				nmt_pkg::REG_CANCEL:     cancel_q    <= cfg_data[2*KW-1:0];
				nmt_pkg::REG_LAYER_KEYS: layer_q     <= cfg_data[2*KW-1:0];
				nmt_pkg::REG_NAV_SPACE:  nav_space_q <= cfg_data[KW-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input stage. It refills in the same cycle it drains, so a transaction
	// can be accepted every cycle while the output side keeps up.
	logic          valid_s1;
	logic          op_s1;
	logic [KW-1:0] kc_s1;
	logic          press_s1;
	logic          nav_s1;
	logic          in_accept;
	logic          advance;

	assign advance       = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1    <= s_axis_tuser;
			kc_s1    <= s_axis_tdata[KW-1:0];
			press_s1 <= s_axis_tdata[KW];
			nav_s1   <= s_axis_tdata[KW+1];
		end
	end

	// Event decode. The ignore list always includes the four low trigger
	// codes, whatever the slot count, plus both layer keys and, while the
	// navigation layer is on, the navigation space key.
	nmt_pkg::event_t ev;
	logic            trig_match;

	always_comb begin
		trig_match = 1'b0;
		for (int k = 0; k < 4; k++) begin
			trig_match = trig_match || (kc_s1 == trig_low_q[k*KW +: KW]);
		end
		ev.force_shot = op_s1;
		ev.keycode    = kc_s1;
		ev.press      = press_s1;
		ev.cancel     = (kc_s1 == cancel_q[KW-1:0]) || (kc_s1 == cancel_q[2*KW-1:KW]);
		ev.ignored    = trig_match ||
		                (kc_s1 == layer_q[KW-1:0]) || (kc_s1 == layer_q[2*KW-1:KW]) ||
		                (nav_s1 && (kc_s1 == nav_space_q));
	end

	// Slot array. All slots see the same event and update together.
	nmt_pkg::slot_result_t slot_res [SLOT_COUNT];

	for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_slot
		logic [KW-1:0] trig;
		if (g < 4) begin : g_low
			assign trig = trig_low_q[g*KW +: KW];
		end else begin : g_last
			assign trig = trig_last_q;
		end
		nmt_slot u_slot (
			.clk        (clk),
			.arst_n     (arst_n),
			.update_en  (advance),
			.ev         (ev),
			.trigger    (trig),
			.mod_mask   (mod_masks_q[g*MW +: MW]),
			.shot_limit (limits_q[g*LW +: LW]),
			.result     (slot_res[g])
		);
	end

	logic [MW-1:0] on_all, off_all;

	always_comb begin
		on_all  = '0;
		off_all = '0;
		for (int k = 0; k < SLOT_COUNT; k++) begin
			on_all  = on_all | slot_res[k].mods_on;
			off_all = off_all | slot_res[k].mods_off;
		end
	end

	// Output register.
	logic          out_valid_q;
	logic [MW-1:0] on_q, off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			on_q  <= on_all;
			off_q <= off_all;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {off_q, on_q};

	// An empty output register never holds back the input side.
	`NMT_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")
	// A staged transaction always reaches the output register when it is free.
	`NMT_ASSERT_NEXT(a_stage_moves, valid_s1 && !m_axis_tvalid, m_axis_tvalid, "staged transaction not moved to output")

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for nshot_modifier_tracker: streams key events and forced one-shots,
// predicts the register and unregister masks per slot and checks every result transaction.
// Depends only on nmt_pkg and the tracker RTL.

module tb_top;
	import nmt_pkg::*;

	localparam int unsigned SLOTS       = 5;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned PRINT_CAP   = 200;

	// Index 7 is not a register; a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

	localparam logic OP_KEY   = 1'b0;
	localparam logic OP_FORCE = 1'b1;

	// Left shift and left control modifier bits, as used by the directed slots.
	localparam logic [MASK_W-1:0] MOD_LCTL = 8'h01;
	localparam logic [MASK_W-1:0] MOD_LSFT = 8'h02;

	typedef struct packed {
		logic                 op;
		logic [KEYCODE_W-1:0] keycode;
		logic                 press;
		logic                 nav;
	} key_txn_t;

	// Same bit order as m_axis_tdata: register mask low, unregister mask high.
	typedef struct packed {
		logic [MASK_W-1:0] to_unreg;
		logic [MASK_W-1:0] to_reg;
	} mod_masks_t;

	typedef enum int {
		CFG_MIXED,
		CFG_LIMIT_MAX,
		CFG_LIMIT_ZERO,
		CFG_SHARED
	} cfg_flavor_t;

	// Clock, reset and DUT ports. Every input starts at a known value.
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [23:0]           s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [15:0]           m_axis_tdata;

	// Bench copy of the configuration registers.
	logic [63:0] cfg_trig_low = '0;
	logic [15:0] cfg_trig_last = '0;
	logic [39:0] cfg_masks = '0;
	logic [19:0] cfg_limits = '0;
	logic [31:0] cfg_cancel = '0;
	logic [31:0] cfg_layer = '0;
	logic [15:0] cfg_nav_space = '0;

	// Bench copy of the per-slot state.
	mode_t            slot_mode [SLOTS];
	logic [USES_W-1:0] slot_uses [SLOTS];

	key_txn_t     stim_q [$];
	mod_masks_t   exp_masks [$];
	logic [15:0]  code_pool [$];

	int unsigned queued_cnt = 0;
	int unsigned err_count = 0;
	int unsigned cycle_cnt = 0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	logic        in_taken = 1'b0;
	logic        no_idle = 1'b0;

	nshot_modifier_tracker #(
		.SLOT_COUNT(SLOTS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	// 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			slot_mode[i] = MODE_IDLE;
			slot_uses[i] = '0;
		end
	end

	function automatic logic [15:0] slot_trigger(input int unsigned i);
		return (i < 4) ? cfg_trig_low[16*i +: 16] : cfg_trig_last;
	endfunction

	// Applies one accepted transaction to the bench slot state and returns the masks the
	// block must report for it. All slots see the same event, so shared triggers act
	// together and the masks are simply ORed.
	function automatic mod_masks_t advance_slots(input key_txn_t t);
		mod_masks_t       r;
		logic             cancel_key;
		logic             skip_key;
		logic             hit;
		logic             bump;
		logic [MASK_W-1:0] m;
		logic [LIMIT_W-1:0] lim;
		logic [USES_W-1:0] end_cnt;
		r = '0;
		cancel_key = (t.keycode == cfg_cancel[15:0]) || (t.keycode == cfg_cancel[31:16]);
		// Keys that never count toward a one-shot: the first four triggers, the layer keys
		// and the space key while the navigation layer is up. The fifth trigger counts.
		skip_key = (t.keycode == cfg_layer[15:0]) || (t.keycode == cfg_layer[31:16]) ||
			(t.nav && t.keycode == cfg_nav_space);
		for (int i = 0; i < 4; i++) begin
			if (t.keycode == cfg_trig_low[16*i +: 16])
				skip_key = 1'b1;
		end
		for (int i = 0; i < SLOTS; i++) begin
			m = cfg_masks[8*i +: 8];
			lim = cfg_limits[4*i +: 4];
			// A limit of zero behaves as one; the slot ends after twice the limit.
			end_cnt = (lim == '0) ? 5'd2 : {lim, 1'b0};
			hit = (t.keycode == slot_trigger(i));
			bump = 1'b0;
			if (t.op == OP_FORCE) begin
				if (hit) begin
					r.to_reg |= m;
					slot_mode[i] = MODE_QUEUED;
					slot_uses[i] = '0;
				end
			end else if (hit) begin
				if (t.press) begin
					if (slot_mode[i] == MODE_IDLE)
						r.to_reg |= m;
					slot_mode[i] = MODE_DOWN_UNUSED;
					slot_uses[i] = '0;
				end else if (slot_mode[i] == MODE_DOWN_UNUSED) begin
					slot_mode[i] = MODE_QUEUED;
				end else if (slot_mode[i] == MODE_DOWN_USED) begin
					slot_mode[i] = MODE_IDLE;
					r.to_unreg |= m;
				end
			end else if (t.press) begin
				if (cancel_key && slot_mode[i] != MODE_IDLE) begin
					slot_mode[i] = MODE_IDLE;
					slot_uses[i] = '0;
					r.to_unreg |= m;
				end
				bump = (slot_mode[i] == MODE_QUEUED) && !skip_key;
			end else if (!skip_key) begin
				if (slot_mode[i] == MODE_DOWN_UNUSED)
					slot_mode[i] = MODE_DOWN_USED;
				else if (slot_mode[i] == MODE_QUEUED)
					bump = 1'b1;
			end
			// The count is five bits wide; after a lowered limit it wraps until it meets
			// the new end value again.
			if (bump) begin
				slot_uses[i] = slot_uses[i] + 5'd1;
				if (slot_uses[i] == end_cnt) begin
					slot_mode[i] = MODE_IDLE;
					slot_uses[i] = '0;
					r.to_unreg |= m;
				end
			end
		end
		return r;
	endfunction

	task automatic report_error(input string what);
		err_count++;
		if (err_count <= PRINT_CAP)
			$display("[%0t ns] mismatch: %s", $realtime, what);
	endtask

	// Mostly short pauses, now and then a long one.
	function automatic int unsigned idle_len();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(0, 3);
		return $urandom_range(8, 30);
	endfunction

	// Driver: presents the next pending transaction at the falling edge, holds it until
	// the monitor has seen it accepted, then waits out a random gap.
	always @(negedge clk) begin
		key_txn_t t;
		if (s_axis_tvalid && !in_taken) begin
			// Transaction still waiting for tready; keep it on the bus.
		end else if (gap_left != 0) begin
			s_axis_tvalid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (stim_q.size() != 0) begin
			t = stim_q.pop_front();
			s_axis_tvalid <= 1'b1;
			s_axis_tuser <= t.op;
			s_axis_tdata <= {6'b0, t.nav, t.press, t.keycode};
			gap_left <= (no_idle || $urandom_range(0, 1) == 0) ? 0 : idle_len();
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// Receiver: random back-pressure on the result side, off during idle-free stretches.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!no_idle && $urandom_range(0, 9) < 2) begin
			m_axis_tready <= 1'b0;
			stall_left <= idle_len();
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Monitor: sees both handshakes at the rising edge. Results are checked before the
	// new input is predicted; a result never belongs to an input taken at the same edge.
	always @(posedge clk) begin
		key_txn_t   t;
		mod_masks_t want;
		in_taken <= s_axis_tvalid && s_axis_tready;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (exp_masks.size() == 0) begin
				report_error($sformatf("result %04h with no transaction outstanding",
					m_axis_tdata));
			end else begin
				want = exp_masks.pop_front();
				if (m_axis_tdata[7:0] !== want.to_reg)
					report_error($sformatf("mods_to_register %02h, predicted %02h",
						m_axis_tdata[7:0], want.to_reg));
				if (m_axis_tdata[15:8] !== want.to_unreg)
					report_error($sformatf("mods_to_unregister %02h, predicted %02h",
						m_axis_tdata[15:8], want.to_unreg));
			end
		end
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			t.op = s_axis_tuser;
			t.keycode = s_axis_tdata[15:0];
			t.press = s_axis_tdata[16];
			t.nav = s_axis_tdata[17];
			exp_masks.push_back(advance_slots(t));
		end
	end

	task automatic push_txn(input logic op, input logic [15:0] kc, input logic press,
		input logic nav);
		key_txn_t t;
		t.op = op;
		t.keycode = kc;
		t.press = press;
		t.nav = nav;
		stim_q.push_back(t);
		queued_cnt++;
	endtask

	// Returns once nothing is pending, on the bus, inside the block or expected. Values are
	// read before the edge updates them, so an edge that moves data always reads as busy.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (stim_q.size() != 0 || s_axis_tvalid || m_axis_tvalid || exp_masks.size() != 0);
	endtask

	// One register write per falling edge; the bench copy keeps only the register width.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_TRIG_LOW:   cfg_trig_low = data;
			REG_TRIG_LAST:  cfg_trig_last = data[15:0];
			REG_MOD_MASKS:  cfg_masks = data[39:0];
			REG_LIMITS:     cfg_limits = data[19:0];
			REG_CANCEL:     cfg_cancel = data[31:0];
			REG_LAYER_KEYS: cfg_layer = data[31:0];
			REG_NAV_SPACE:  cfg_nav_space = data[15:0];
			default: ;
		endcase
	endtask

	// Writes every register plus the unused index, then rebuilds the pool of keycodes that
	// matter under the new setting so random traffic keeps hitting them.
	task automatic load_config(input logic [63:0] trig_low, input logic [63:0] trig_last,
		input logic [63:0] masks, input logic [63:0] lims, input logic [63:0] cancel,
		input logic [63:0] layer, input logic [63:0] nav);
		write_reg(REG_TRIG_LOW, trig_low);
		write_reg(REG_TRIG_LAST, trig_last);
		write_reg(REG_MOD_MASKS, masks);
		write_reg(REG_LIMITS, lims);
		write_reg(REG_CANCEL, cancel);
		write_reg(REG_LAYER_KEYS, layer);
		write_reg(REG_NAV_SPACE, nav);
		write_reg(REG_NONE, {$urandom, $urandom});
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		code_pool.delete();
		for (int i = 0; i < SLOTS; i++)
			code_pool.push_back(slot_trigger(i));
		code_pool.push_back(cfg_cancel[15:0]);
		code_pool.push_back(cfg_cancel[31:16]);
		code_pool.push_back(cfg_layer[15:0]);
		code_pool.push_back(cfg_layer[31:16]);
		code_pool.push_back(cfg_nav_space);
		// Plain letter keys carry most of the counting.
		for (int i = 0; i < 8; i++)
			code_pool.push_back(16'h0004 + 16'(i % 4));
	endtask

	function automatic logic [15:0] pick_code();
		if ($urandom_range(0, 3) == 0)
			return 16'($urandom);
		return code_pool[$urandom_range(0, code_pool.size() - 1)];
	endfunction

	task automatic random_config(input cfg_flavor_t flavor);
		logic [15:0] trig [SLOTS];
		logic [15:0] shared_code;
		logic [39:0] masks;
		logic [19:0] lims;
		logic [15:0] cancel_a;
		logic [15:0] layer_a;
		logic [15:0] nav;
		shared_code = 16'h00E0 + 16'($urandom_range(0, 5));
		for (int i = 0; i < SLOTS; i++) begin
			if (flavor == CFG_SHARED)
				trig[i] = shared_code;
			else if ($urandom_range(0, 3) == 0)
				trig[i] = 16'($urandom);
			else
				trig[i] = 16'h00E0 + 16'($urandom_range(0, 5));
			case (flavor)
				CFG_LIMIT_MAX:  lims[4*i +: 4] = 4'hF;
				CFG_LIMIT_ZERO: lims[4*i +: 4] = 4'h0;
				default:        lims[4*i +: 4] = ($urandom_range(0, 1) == 0) ?
					4'($urandom_range(0, 3)) : 4'($urandom);
			endcase
		end
		masks = (flavor == CFG_SHARED) ? '1 : 40'({$urandom, $urandom});
		// Now and then a cancel key is also a trigger; the trigger role wins for that slot.
		cancel_a = ($urandom_range(0, 7) == 0) ? trig[$urandom_range(0, SLOTS - 1)] :
			16'h0029 + 16'($urandom_range(0, 3));
		layer_a = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
			16'h7E00 + 16'($urandom_range(0, 3));
		nav = ($urandom_range(0, 1) == 0) ? 16'h002C : 16'h0004 + 16'($urandom_range(0, 3));
		load_config({trig[3], trig[2], trig[1], trig[0]},
			{$urandom, 16'($urandom), trig[4]},
			{24'($urandom), masks},
			{$urandom, 12'($urandom), lims},
			{$urandom, 16'h0029 + 16'($urandom_range(0, 3)), cancel_a},
			{$urandom, 16'h7E00 + 16'($urandom_range(0, 3)), layer_a},
			{$urandom, 16'($urandom), nav});
	endtask

	// Mostly well-formed one-shot use: press a trigger, maybe tap keys while it is held,
	// release it, then type a few keys. The rest is stray keys and forced one-shots.
	task automatic random_phase(input int unsigned n_items);
		int unsigned stop_at;
		int unsigned slot;
		logic [15:0] trig;
		logic [15:0] other;
		stop_at = queued_cnt + n_items;
		while (queued_cnt < stop_at) begin
			if ($urandom_range(0, 9) < 6) begin
				slot = $urandom_range(0, SLOTS - 1);
				trig = slot_trigger(slot);
				push_txn(OP_KEY, trig, 1'b1, 1'($urandom));
				repeat ($urandom_range(0, 2)) begin
					other = pick_code();
					push_txn(OP_KEY, other, 1'b1, 1'($urandom));
					push_txn(OP_KEY, other, 1'b0, 1'($urandom));
				end
				push_txn(OP_KEY, trig, 1'b0, 1'($urandom));
				repeat ($urandom_range(0, 6))
					push_txn(OP_KEY, pick_code(), 1'($urandom), 1'($urandom));
			end else if ($urandom_range(0, 7) == 0) begin
				trig = ($urandom_range(0, 4) == 0) ? 16'($urandom) :
					slot_trigger($urandom_range(0, SLOTS - 1));
				push_txn(OP_FORCE, trig, 1'($urandom), 1'($urandom));
			end else begin
				push_txn(OP_KEY, pick_code(), 1'($urandom), 1'($urandom));
			end
		end
	endtask

	// Timeout guard, far above the slowest legal run.
	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("FAILURE");
		$finish;
	end

	// Test sequence.
	initial begin
		cfg_flavor_t flavor;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Straight out of reset every code is zero, so keycode 0 is trigger, cancel and
		// layer key at once and all masks are empty.
		push_txn(OP_KEY, 16'h0000, 1'b1, 1'b0);
		push_txn(OP_KEY, 16'hFFFF, 1'b0, 1'b1);
		push_txn(OP_FORCE, 16'h0000, 1'b1, 1'b1);
		wait_drained();

		// Directed setting: slot 0 is left shift with limit 1, slot 1 left control with
		// limit 0, slot 2 limit 15, slot 3 limit 2, slot 4 limit 1. Upper bits of the
		// narrow registers carry junk that must be dropped.
		load_config(64'h00E3_00E2_00E0_00E1, 64'hABCD_0000_1234_00E4,
			{24'hFFFFFF, 8'h30, 8'h08, 8'h04, MOD_LCTL, MOD_LSFT},
			64'hFFFF_FFFF_FFF1_2F01, 64'h5A5A_5A5A_FFFF_0029,
			64'hA5A5_A5A5_0000_7E01, 64'hFFFF_FFFF_FFFF_002C);

		// Tap-and-release one-shot that ends after two counted key events.
		push_txn(OP_KEY, 16'h00E1, 1'b1, 1'b0);
		push_txn(OP_KEY, 16'h00E1, 1'b0, 1'b0);
		push_txn(OP_KEY, 16'h0004, 1'b1, 1'b0);
		push_txn(OP_KEY, 16'h0004, 1'b0, 1'b0);
		// Held modifier: a key released while the trigger is down makes it a plain
		// modifier that goes off with the trigger.
		push_txn(OP_KEY, 16'h00E0, 1'b1, 1'b0);
		push_txn(OP_KEY, 16'h0005, 1'b1, 1'b0);
		push_txn(OP_KEY, 16'h0005, 1'b0, 1'b0);
		push_txn(OP_KEY, 16'h00E0, 1'b0, 1'b0);
		// Queued slot: layer and navigation-layer space keys do not count, a plain space does.
		push_txn(OP_KEY, 16'h00E2, 1'b1, 1'b1);
		push_txn(OP_KEY, 16'h00E2, 1'b0, 1'b0);
		push_txn(OP_KEY, 16'h7E01, 1'b1, 1'b0);
		push_txn(OP_KEY, 16'h002C, 1'b1, 1'b1);
		push_txn(OP_KEY, 16'h002C, 1'b1, 1'b0);
		// Forced one-shot, then a cancel press ends both active slots.
		push_txn(OP_FORCE, 16'h00E3, 1'b0, 1'b0);
		push_txn(OP_KEY, 16'h0029, 1'b1, 1'b0);
		// The fifth trigger is not skipped by the others; releasing the second cancel key
		// counts, pressing it cancels.
		push_txn(OP_KEY, 16'h00E4, 1'b1, 1'b1);
		push_txn(OP_KEY, 16'h00E4, 1'b0, 1'b1);
		push_txn(OP_KEY, 16'h0000, 1'b1, 1'b0);
		push_txn(OP_KEY, 16'hFFFF, 1'b0, 1'b0);
		push_txn(OP_KEY, 16'hFFFF, 1'b1, 1'b1);
		// Force with no matching slot, and a force while the trigger is held down.
		push_txn(OP_FORCE, 16'h1234, 1'b1, 1'b1);
		push_txn(OP_KEY, 16'h00E1, 1'b1, 1'b0);
		push_txn(OP_FORCE, 16'h00E1, 1'b0, 1'b1);
		push_txn(OP_KEY, 16'hFFFF, 1'b1, 1'b0);
		wait_drained();

		// Random phases, each with a new setting written while the block is drained. Slot
		// state carries across phases, so counts left high by the maximum-limit phase run
		// past the lowered end in the zero-limit phase and wrap.
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: flavor = CFG_LIMIT_MAX;
				1: flavor = CFG_LIMIT_ZERO;
				3: flavor = CFG_SHARED;
				default: flavor = CFG_MIXED;
			endcase
			// One phase runs at full rate on both sides.
			no_idle = (p == 2);
			random_config(flavor);
			random_phase(108);
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
